### rtl/brpd_pkg.sv
// ----------------------------------------------------------------------------
// brpd_pkg
// Shared types and codes for the byte ring with peek and discard.
// ----------------------------------------------------------------------------
package brpd_pkg;

    localparam int LVL_W   = 13;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 3;
    localparam int CNT_W   = 13;
    localparam int WDATA_W = 64;

    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_DISCARD = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NO_DATA     = 3'd2;
    localparam logic [STAT_W-1:0] ST_NO_DISCARD  = 3'd3;
    localparam logic [STAT_W-1:0] ST_TOO_LONG    = 3'd4;

    localparam logic [LVL_W-1:0] RING_SIZE_RESET = 13'd4096;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [CNT_W-1:0]   count;
        logic [WDATA_W-1:0] write_bytes;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              data_valid;
        logic [7:0]        out_byte;
        logic              last;
        logic [LVL_W-1:0]  level;
    } rsp_t;

endpackage

### rtl/brpd_store.sv
// ----------------------------------------------------------------------------
// brpd_store
// Byte-wide ring store: one write port, one read port, registered read data
// that holds until the next read.
// ----------------------------------------------------------------------------
module brpd_store #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/brpd_seq.sv
// ----------------------------------------------------------------------------
// brpd_seq
// Request decode, ring pointers and byte sequencer with the result register.
// Writes walk the store one byte a cycle; peeks stream reads one ahead.
// ----------------------------------------------------------------------------
module brpd_seq #(
    parameter int STORE_DEPTH = 4096,
    parameter int MAX_RUN     = 64,
    parameter int WRITE_LANES = 8,
    parameter int AW          = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  brpd_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output brpd_pkg::rsp_t                   rsp,
    input  logic [brpd_pkg::LVL_W-1:0]       ring_size,
    input  logic                             cfg_wr,
    output logic                             mem_we,
    output logic [AW-1:0]                    mem_waddr,
    output logic [7:0]                       mem_wdata,
    output logic                             mem_re,
    output logic [AW-1:0]                    mem_raddr,
    input  logic [7:0]                       mem_rdata
);

    import brpd_pkg::*;

    localparam int PW    = (AW < LVL_W) ? AW : LVL_W;
    localparam int SW    = LVL_W + 1;
    localparam int RUN_W = $clog2(MAX_RUN + 1);
    localparam int LN_W  = $clog2(WRITE_LANES + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_PEEK  = 2'd2;
    localparam logic [1:0] S_RESP  = 2'd3;

    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                               input logic [LVL_W-1:0] b,
                                               input logic [LVL_W-1:0] sz);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(sz))
        begin
            s = s - SW'(sz);
        end
        return s[PW-1:0];
    endfunction

    logic [1:0]         state_reg, state_next;
    logic [PW-1:0]      head_reg, head_next;
    logic [LVL_W-1:0]   held_reg, held_next;
    logic               armed_reg, armed_next;
    logic [STAT_W-1:0]  status_reg, status_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [WDATA_W-1:0] wbytes_reg, wbytes_next;
    logic [LN_W-1:0]    wleft_reg, wleft_next;
    logic [RUN_W-1:0]   issue_left_reg, issue_left_next;
    logic [RUN_W-1:0]   emit_left_reg, emit_left_next;
    logic               pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    rsp_t               out_reg, out_next;

    logic [LVL_W-1:0]   size;
    logic               can_emit;
    logic               emit_byte;
    logic               issue;
    logic               emit;
    logic [SW-1:0]      fill_sum;

    // effective ring length: zero acts as one, saturate at the store depth
    always_comb
    begin
        if (ring_size == '0)
        begin
            size = LVL_W'(1);
        end
        else if (32'(ring_size) > 32'(STORE_DEPTH))
        begin
            size = LVL_W'(STORE_DEPTH);
        end
        else
        begin
            size = ring_size;
        end
    end

    assign can_emit  = !out_valid_reg || !rsp_stall;
    assign emit_byte = (state_reg == S_PEEK) && pend_reg && can_emit;
    // never overwrite read data that has not yet gone out
    assign issue     = (state_reg == S_PEEK) && (issue_left_reg != '0)
                       && (!pend_reg || can_emit);
    assign fill_sum  = SW'(held_reg) + SW'(req.count);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        held_next       = held_reg;
        armed_next      = armed_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        wbytes_next     = wbytes_reg;
        wleft_next      = wleft_reg;
        issue_left_next = issue_left_reg;
        emit_left_next  = emit_left_reg;
        pend_next       = pend_reg;
        emit            = 1'b0;
        out_next        = out_reg;
        mem_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    case (req.mode)
                        MODE_WRITE:
                        begin
                            if (32'(req.count) > 32'(WRITE_LANES))
                            begin
                                status_next = ST_TOO_LONG;
                            end
                            else if (fill_sum > SW'(size))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                pos_next    = wrap_add(head_reg, held_reg, size);
                                wbytes_next = req.write_bytes;
                                wleft_next  = req.count[LN_W-1:0];
                                held_next   = fill_sum[LVL_W-1:0];
                                if (req.count != '0)
                                begin
                                    state_next = S_WRITE;
                                end
                            end
                        end
                        MODE_PEEK, MODE_READ:
                        begin
                            if (32'(req.count) > 32'(MAX_RUN))
                            begin
                                status_next = ST_TOO_LONG;
                            end
                            else if (held_reg < req.count)
                            begin
                                status_next = ST_NO_DATA;
                            end
                            else
                            begin
                                pos_next        = head_reg;
                                issue_left_next = req.count[RUN_W-1:0];
                                emit_left_next  = req.count[RUN_W-1:0];
                                pend_next       = 1'b0;
                                armed_next      = 1'b1;
                                if (req.mode == MODE_READ)
                                begin
                                    head_next  = wrap_add(head_reg, req.count, size);
                                    held_next  = held_reg - req.count;
                                    armed_next = 1'b0;
                                end
                                if (req.count != '0)
                                begin
                                    state_next = S_PEEK;
                                end
                            end
                        end
                        MODE_DISCARD:
                        begin
                            if (!armed_reg)
                            begin
                                status_next = ST_NO_DISCARD;
                            end
                            else if (held_reg < req.count)
                            begin
                                status_next = ST_NO_DATA;
                            end
                            else
                            begin
                                head_next  = wrap_add(head_reg, req.count, size);
                                held_next  = held_reg - req.count;
                                armed_next = 1'b0;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            head_next  = '0;
                            held_next  = '0;
                            armed_next = 1'b0;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_WRITE:
            begin
                mem_we      = 1'b1;
                pos_next    = wrap_add(pos_reg, LVL_W'(1), size);
                wbytes_next = wbytes_reg >> 8;
                wleft_next  = wleft_reg - LN_W'(1);
                if (wleft_reg == LN_W'(1))
                begin
                    state_next = S_RESP;
                end
            end
            S_PEEK:
            begin
                if (issue)
                begin
                    pos_next        = wrap_add(pos_reg, LVL_W'(1), size);
                    issue_left_next = issue_left_reg - RUN_W'(1);
                    pend_next       = 1'b1;
                end
                else if (emit_byte)
                begin
                    pend_next = 1'b0;
                end
                if (emit_byte)
                begin
                    emit                = 1'b1;
                    out_next.status     = ST_OK;
                    out_next.data_valid = 1'b1;
                    out_next.out_byte   = mem_rdata;
                    out_next.last       = (emit_left_reg == RUN_W'(1));
                    out_next.level      = held_reg;
                    emit_left_next      = emit_left_reg - RUN_W'(1);
                    if (emit_left_reg == RUN_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RESP:
            begin
                if (can_emit)
                begin
                    emit                = 1'b1;
                    out_next.status     = status_reg;
                    out_next.data_valid = 1'b0;
                    out_next.out_byte   = '0;
                    out_next.last       = 1'b1;
                    out_next.level      = held_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a ring size write empties the ring
        if (cfg_wr)
        begin
            head_next  = '0;
            held_next  = '0;
            armed_next = 1'b0;
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            held_reg       <= '0;
            armed_reg      <= 1'b0;
            issue_left_reg <= '0;
            emit_left_reg  <= '0;
            wleft_reg      <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            held_reg       <= held_next;
            armed_reg      <= armed_next;
            issue_left_reg <= issue_left_next;
            emit_left_reg  <= emit_left_next;
            wleft_reg      <= wleft_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pos_reg    <= pos_next;
        wbytes_reg <= wbytes_next;
        out_reg    <= out_next;
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign mem_waddr = AW'(pos_reg);
    assign mem_wdata = wbytes_reg[7:0];
    assign mem_re    = issue;
    assign mem_raddr = AW'(pos_reg);

`ifndef SYNTHESIS
    a_held_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= size)
        else $error("held byte count exceeds ring size");

    a_head_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
        LVL_W'(head_reg) < size)
        else $error("head offset outside ring");

    a_peek_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PEEK) |->
            (emit_left_reg == issue_left_reg + RUN_W'(pend_reg)))
        else $error("peek reads and emitted bytes out of step");

    a_cfg_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (held_reg == '0) && !armed_reg)
        else $error("ring not emptied after size write");
`endif

endmodule

### rtl/byte_ring_peek_discard_fifo_unit.sv
// Writes: a write of n bytes (n up to WRITE_LANES) stores them one after another
// once the request is taken; its result is registered after the last byte.
// A peek or read of n bytes shows its first byte after the store read and result
// registers, then one byte a cycle unless rsp_stall holds the output; the store's
// single read port sets that pace. req_stall is high while a request is in progress.
// Reset: ring empty, discard disarmed, ring size 4096; store contents undefined.
// ----------------------------------------------------------------------------
// byte_ring_peek_discard_fifo_unit
// Byte ring FIFO with peek and discard, ring size register on an APB port.
// ----------------------------------------------------------------------------
module byte_ring_peek_discard_fifo_unit #(
    parameter int STORE_DEPTH = 4096,
    parameter int MAX_RUN     = 64,
    parameter int WRITE_LANES = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  brpd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output brpd_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import brpd_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);

    logic [LVL_W-1:0] ring_size_reg;
    logic             cfg_wr;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [7:0]       mem_rdata;

    assign pready = 1'b1;
    // only one register: writes at every address decode to it; reads return it at address 0 only
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = {{(32 - LVL_W){1'b0}}, ring_size_reg} & {32{paddr == 2'd0}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= RING_SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            ring_size_reg <= pwdata[LVL_W-1:0];
        end
    end

    brpd_seq #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RUN     (MAX_RUN),
        .WRITE_LANES (WRITE_LANES),
        .AW          (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .ring_size (ring_size_reg),
        .cfg_wr    (cfg_wr),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    brpd_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

### dv/brpd_ring_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brpd_ring_checker
// Watches the request, response and register ports of the byte ring, keeps a
// shadow ring with its own head, level and discard flag, and compares every
// accepted response field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module brpd_ring_checker #(
    parameter int         STORE_DEPTH = 4096,
    parameter int         MAX_RUN     = 64,
    parameter int         WRITE_LANES = 8,
    parameter logic [1:0] RING_ADDR   = 2'd0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  brpd_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  brpd_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic           pready,
    input  logic [1:0]     paddr,
    input  logic [31:0]    pwdata,
    output int             err_count,
    output int             pending,
    output int             held_level
);
    import brpd_pkg::*;

    logic [7:0]       ring_mem [STORE_DEPTH];
    int               head;
    int               held;
    bit               armed;
    logic [LVL_W-1:0] ring_reg;
    rsp_t             ring_expect [$];
    rsp_t             want;
    int               errors = 0;

    assign err_count = errors;

    function automatic int ring_span();
        if (ring_reg == '0)
            return 1;
        if (int'(ring_reg) > STORE_DEPTH)
            return STORE_DEPTH;
        return int'(ring_reg);
    endfunction

    function automatic int ring_advance(input int a, input int b, input int span);
        int s;
        s = a + b;
        if (s >= span)
            s = s - span;
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        errors++;
        $display("checker: %0t %s", $time, msg);
    endtask

    // level is taken after the whole request has been applied
    task automatic push_result(input logic [STAT_W-1:0] st, input logic dv,
                               input logic [7:0] b, input logic lst);
        rsp_t e;
        e.status     = st;
        e.data_valid = dv;
        e.out_byte   = b;
        e.last       = lst;
        e.level      = held[LVL_W-1:0];
        ring_expect.push_back(e);
    endtask

    task automatic predict_request(input req_t r);
        int         span;
        int         cnt;
        int         pos;
        logic [7:0] run_bytes [MAX_RUN];
        span = ring_span();
        cnt  = int'(r.count);
        case (r.mode)
            MODE_WRITE:
            begin
                if (cnt > WRITE_LANES)
                    push_result(ST_TOO_LONG, 1'b0, 8'h00, 1'b1);
                else if (held + cnt > span)
                    push_result(ST_OVERFLOW, 1'b0, 8'h00, 1'b1);
                else
                begin
                    pos = ring_advance(head, held, span);
                    for (int i = 0; i < cnt; i++)
                    begin
                        ring_mem[pos] = r.write_bytes[8*i +: 8];
                        pos = ring_advance(pos, 1, span);
                    end
                    held = held + cnt;
                    push_result(ST_OK, 1'b0, 8'h00, 1'b1);
                end
            end
            MODE_PEEK, MODE_READ:
            begin
                if (cnt > MAX_RUN)
                    push_result(ST_TOO_LONG, 1'b0, 8'h00, 1'b1);
                else if (held < cnt)
                    push_result(ST_NO_DATA, 1'b0, 8'h00, 1'b1);
                else
                begin
                    pos = head;
                    for (int i = 0; i < cnt; i++)
                    begin
                        run_bytes[i] = ring_mem[pos];
                        pos = ring_advance(pos, 1, span);
                    end
                    armed = 1'b1;
                    if (r.mode == MODE_READ)
                    begin
                        head  = ring_advance(head, cnt, span);
                        held  = held - cnt;
                        armed = 1'b0;
                    end
                    if (cnt == 0)
                        push_result(ST_OK, 1'b0, 8'h00, 1'b1);
                    for (int i = 0; i < cnt; i++)
                        push_result(ST_OK, 1'b1, run_bytes[i], i == cnt - 1);
                end
            end
            MODE_DISCARD:
            begin
                // the flag is checked before the level
                if (!armed)
                    push_result(ST_NO_DISCARD, 1'b0, 8'h00, 1'b1);
                else if (held < cnt)
                    push_result(ST_NO_DATA, 1'b0, 8'h00, 1'b1);
                else
                begin
                    head  = ring_advance(head, cnt, span);
                    held  = held - cnt;
                    armed = 1'b0;
                    push_result(ST_OK, 1'b0, 8'h00, 1'b1);
                end
            end
            MODE_CLEAR:
            begin
                head  = 0;
                held  = 0;
                armed = 1'b0;
                push_result(ST_OK, 1'b0, 8'h00, 1'b1);
            end
            default:
                push_result(ST_OK, 1'b0, 8'h00, 1'b1);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head     = 0;
            held     = 0;
            armed    = 1'b0;
            ring_reg = RING_SIZE_RESET;
            ring_expect.delete();
            pending    <= 0;
            held_level <= 0;
        end
        else
        begin
            // a ring size write also empties the ring
            if (psel && penable && pwrite && pready && paddr == RING_ADDR)
            begin
                ring_reg = pwdata[LVL_W-1:0];
                head     = 0;
                held     = 0;
                armed    = 1'b0;
            end
            if (req_valid && !req_stall)
                predict_request(req);
            if (rsp_valid && !rsp_stall)
            begin
                if (ring_expect.size() == 0)
                    report_mismatch($sformatf("response with nothing expected, status %0d",
                                              rsp.status));
                else
                begin
                    want = ring_expect.pop_front();
                    if (rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  rsp.status, want.status));
                    if (rsp.data_valid !== want.data_valid)
                        report_mismatch($sformatf("data_valid got %0d want %0d",
                                                  rsp.data_valid, want.data_valid));
                    if (rsp.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte got %02h want %02h",
                                                  rsp.out_byte, want.out_byte));
                    if (rsp.last !== want.last)
                        report_mismatch($sformatf("last got %0d want %0d",
                                                  rsp.last, want.last));
                    if (rsp.level !== want.level)
                        report_mismatch($sformatf("level got %0d want %0d",
                                                  rsp.level, want.level));
                end
            end
            pending    <= ring_expect.size();
            held_level <= held;
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the byte ring with a directed pass over the status cases and wrap,
// then random request mixes under several ring sizes and idle patterns; the
// checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
    import brpd_pkg::*;

    localparam int         STORE_DEPTH     = 4096;
    localparam int         MAX_RUN         = 64;
    localparam int         WRITE_LANES     = 8;
    localparam logic [1:0] RING_SIZE_ADDR  = 2'd0;
    localparam int         WATCHDOG_LIMIT  = 4000;
    localparam int         ITEMS_PER_PHASE = 31;
    localparam int         CNT_MAX         = (1 << CNT_W) - 1;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_t        rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [1:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int err_count;
    int pending;
    int held_level;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int ring_eff      = STORE_DEPTH;
    bit after_peek    = 1'b0;
    int idle_cycles   = 0;
    int ring_plan [8] = '{13, 1, 0, 100, 8191, 64, 4097, 4096};

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    byte_ring_peek_discard_fifo_unit #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RUN     (MAX_RUN),
        .WRITE_LANES (WRITE_LANES)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    brpd_ring_checker #(
        .STORE_DEPTH (STORE_DEPTH),
        .MAX_RUN     (MAX_RUN),
        .WRITE_LANES (WRITE_LANES),
        .RING_ADDR   (RING_SIZE_ADDR)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .err_count  (err_count),
        .pending    (pending),
        .held_level (held_level)
    );

    always @(posedge clk)
        rsp_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("testbench: done, errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // hold valid and payload until the block takes the request
    task automatic send_req(input req_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic issue(input logic [MODE_W-1:0] m, input int cnt,
                         input logic [WDATA_W-1:0] d);
        req_t r;
        r.mode        = m;
        r.count       = cnt[CNT_W-1:0];
        r.write_bytes = d;
        send_req(r);
    endtask

    // drop valid, then wait for every predicted response plus the write tail
    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2 * WRITE_LANES) @(posedge clk);
    endtask

    task automatic set_ring(input int value);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= RING_SIZE_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (value[LVL_W-1:0] == '0)
            ring_eff = 1;
        else if (int'(value[LVL_W-1:0]) > STORE_DEPTH)
            ring_eff = STORE_DEPTH;
        else
            ring_eff = int'(value[LVL_W-1:0]);
    endtask

    // mostly well-formed requests sized from the (one request stale) level
    task automatic random_request();
        int                 lvl;
        int                 room;
        int                 pick;
        int                 cnt;
        int                 lim;
        logic [MODE_W-1:0]  m;
        logic [WDATA_W-1:0] d;
        lvl  = held_level;
        d    = {$urandom, $urandom};
        pick = $urandom_range(0, 99);
        if (after_peek && $urandom_range(0, 1) == 1)
            pick = 80;
        if (pick < 36)
        begin
            m    = MODE_WRITE;
            room = ring_eff - lvl;
            if (room < 0)
                room = 0;
            if (room > WRITE_LANES)
                room = WRITE_LANES;
            case ($urandom_range(0, 9))
                0:       cnt = $urandom_range(0, CNT_MAX);
                1:       cnt = $urandom_range(0, WRITE_LANES);
                default: cnt = $urandom_range(0, room);
            endcase
        end
        else if (pick < 70)
        begin
            m   = (pick < 52) ? MODE_PEEK : MODE_READ;
            lim = (lvl < MAX_RUN) ? lvl : MAX_RUN;
            case ($urandom_range(0, 9))
                0:       cnt = $urandom_range(0, CNT_MAX);
                1:       cnt = $urandom_range(0, MAX_RUN);
                default: cnt = $urandom_range(0, lim);
            endcase
        end
        else if (pick < 92)
        begin
            m = MODE_DISCARD;
            if ($urandom_range(0, 9) == 0)
                cnt = $urandom_range(0, CNT_MAX);
            else
                cnt = $urandom_range(0, lvl);
        end
        else if (pick < 96)
        begin
            m   = MODE_CLEAR;
            cnt = $urandom_range(0, CNT_MAX);
        end
        else
        begin
            // undefined modes above clear
            m   = MODE_CLEAR + MODE_W'($urandom_range(1, 3));
            cnt = $urandom_range(0, CNT_MAX);
        end
        after_peek = (m == MODE_PEEK);
        issue(m, cnt, d);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // status cases on the reset ring size
        issue(MODE_DISCARD, 0, {$urandom, $urandom});
        issue(MODE_PEEK, 1, {$urandom, $urandom});
        issue(MODE_PEEK, 0, {$urandom, $urandom});
        issue(MODE_DISCARD, 1, {$urandom, $urandom});
        issue(MODE_DISCARD, 0, {$urandom, $urandom});
        issue(MODE_WRITE, WRITE_LANES + 1, '1);
        issue(MODE_WRITE, CNT_MAX, '1);
        issue(MODE_WRITE, 0, '1);
        issue(MODE_WRITE, WRITE_LANES, '1);
        issue(MODE_WRITE, WRITE_LANES, '0);
        repeat (7) issue(MODE_WRITE, WRITE_LANES, {$urandom, $urandom});
        issue(MODE_PEEK, MAX_RUN + 1, '0);
        issue(MODE_PEEK, MAX_RUN, '1);
        issue(MODE_DISCARD, MAX_RUN + 6, '0);
        issue(MODE_READ, 3, '0);
        issue(MODE_READ, 2, '0);
        issue(MODE_READ, 0, '0);
        issue(MODE_CLEAR + 3'd3, CNT_MAX, '1);
        issue(MODE_CLEAR, 0, '0);

        // wrap on a tiny ring
        set_ring(5);
        issue(MODE_WRITE, 4, {$urandom, $urandom});
        issue(MODE_WRITE, 2, {$urandom, $urandom});
        issue(MODE_READ, 3, '0);
        issue(MODE_WRITE, 4, {$urandom, $urandom});
        issue(MODE_PEEK, 5, '0);
        issue(MODE_READ, 5, '0);

        for (int p = 0; p < 8; p++)
        begin
            set_ring(ring_plan[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 0;
                end
                1:
                begin
                    send_idle_pct = 82;
                    stall_pct    <= 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct    <= 82;
                end
                default:
                begin
                    send_idle_pct = 20;
                    stall_pct    <= 20;
                end
            endcase
            repeat (ITEMS_PER_PHASE) random_request();
        end

        drain();
        if (err_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/brpd_pkg.sv
rtl/brpd_store.sv
rtl/brpd_seq.sv
rtl/byte_ring_peek_discard_fifo_unit.sv
dv/brpd_ring_checker.sv
dv/testbench.sv
